FILE: sv/assert_macros.svh
// Concurrent assertion helpers shared by the RTL modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: sv/das_pkg.sv
package das_pkg;

  localparam int MOTORS_DEF  = 6;
  localparam int DETENTS_DEF = 4;

  localparam int MOTOR_W   = 3;
  localparam int SLOT_W    = 2;
  localparam int READ_W    = 12;
  localparam int POS_W     = 32;
  localparam int TOL_W     = 11;
  localparam int STEP_W    = 10;
  localparam int PASS_W    = 16;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;

  localparam int ENC_RANGE = 4096;
  localparam int HALF_RANGE = ENC_RANGE / 2;
  localparam int DIST_W    = $clog2(ENC_RANGE) + 1;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_RECORD = 3'd2,
    CMD_BEGIN  = 3'd3,
    CMD_ALIGN  = 3'd4,
    CMD_END    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ACK     = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_TOL        = 2'd0,
    REG_STEP       = 2'd1,
    REG_ALIGN_TO   = 2'd2,
    REG_HOME_TO    = 2'd3
  } reg_e;

  typedef struct packed {
    logic [TOL_W-1:0]  tol;
    logic [STEP_W-1:0] step;
    logic [PASS_W-1:0] align_to;
    logic [PASS_W-1:0] home_to;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [MOTOR_W-1:0] motor;
    logic [READ_W-1:0]  reading;
    logic               selective;
    logic               mark;
  } item_t;

  typedef struct packed {
    logic [MOTOR_W-1:0]      motor_out;
    logic signed [POS_W-1:0] position;
    logic                    in_tol;
    logic [READ_W-1:0]       target;
    status_e                 status;
  } res_t;

  // Wraparound distance between two encoder values, clamped at zero.
  function automatic logic [DIST_W-1:0] wrap_dist(input logic [READ_W-1:0] a,
                                                  input logic [READ_W-1:0] b);
    logic [DIST_W-1:0] d;
    logic [DIST_W:0]   w;
    d = (a > b) ? DIST_W'(a - b) : DIST_W'(b - a);
    if (d > DIST_W'(HALF_RANGE)) begin
      w = (DIST_W+1)'(ENC_RANGE) - {1'b0, d};
      d = w[DIST_W] ? '0 : w[DIST_W-1:0];
    end
    return d;
  endfunction

endpackage

FILE: sv/das_cfg_regs.sv
module das_cfg_regs
  import das_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  reg_e sel;
  logic wr;

  assign pready = 1'b1;
  assign sel    = reg_e'(paddr[APB_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tol      <= TOL_W'(20);
      cfg_r.step     <= STEP_W'(1);
      cfg_r.align_to <= PASS_W'(1000);
      cfg_r.home_to  <= PASS_W'(5000);
    end else if (wr) begin
      case (sel)
        REG_TOL:      cfg_r.tol      <= pwdata[TOL_W-1:0];
        REG_STEP:     cfg_r.step     <= pwdata[STEP_W-1:0];
        REG_ALIGN_TO: cfg_r.align_to <= pwdata[PASS_W-1:0];
        REG_HOME_TO:  cfg_r.home_to  <= pwdata[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_TOL:      prdata = APB_DW'(cfg_r.tol);
      REG_STEP:     prdata = APB_DW'(cfg_r.step);
      REG_ALIGN_TO: prdata = APB_DW'(cfg_r.align_to);
      REG_HOME_TO:  prdata = APB_DW'(cfg_r.home_to);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: sv/das_detent_mem.sv
module das_detent_mem
  import das_pkg::*;
#(
  parameter int MOTORS  = MOTORS_DEF,
  parameter int DETENTS = DETENTS_DEF,
  localparam int MOT_W  = (MOTORS > 1) ? $clog2(MOTORS) : 1,
  localparam int DET_W  = $clog2(DETENTS)
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [MOT_W-1:0]                 wr_motor,
  input  logic [DET_W-1:0]                 wr_slot,
  input  logic [READ_W-1:0]                wr_data,
  input  logic                             rd_en,
  input  logic [MOT_W-1:0]                 rd_motor,
  output logic [DETENTS-1:0][READ_W-1:0]   rd_data
);

  // One row per motor, one slot written at a time, whole row read.
  logic [DETENTS-1:0][READ_W-1:0] mem_r [MOTORS];
  logic [DETENTS-1:0][READ_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_motor][wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_motor];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/das_align_core.sv
`include "assert_macros.svh"
module das_align_core
  import das_pkg::*;
#(
  parameter int MOTORS  = MOTORS_DEF,
  parameter int DETENTS = DETENTS_DEF,
  localparam int MOT_W  = (MOTORS > 1) ? $clog2(MOTORS) : 1,
  localparam int DET_W  = $clog2(DETENTS)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  item_t                          item,
  input  logic [DETENTS-1:0][READ_W-1:0] detents,
  input  cfg_t                           cfg,
  output res_t                           res
);

  typedef struct packed {
    logic [DET_W-1:0]  idx;
    logic [DIST_W-1:0] gap;
  } near_t;

  logic signed [POS_W-1:0] pos_r [MOTORS];
  logic signed [POS_W-1:0] pos_nxt [MOTORS];
  logic [DET_W-1:0]        start_idx_r [MOTORS];
  logic [DET_W-1:0]        start_idx_nxt [MOTORS];
  logic [MOTORS-1:0]       start_vld_r, start_vld_nxt;
  logic [MOTORS-1:0]       moved_r, moved_nxt;
  logic                    aligned_r, aligned_nxt;
  logic [PASS_W-1:0]       cnt_r, cnt_nxt;

  logic                    motor_ok;
  logic [MOT_W-1:0]        mi;
  logic                    skip_en;
  near_t                   near_all, near_skip;
  logic [PASS_W-1:0]       cnt_inc, limit;
  logic [READ_W-1:0]       tv;
  logic signed [POS_W-1:0] step_s;

  function automatic near_t nearest(input logic [DETENTS-1:0][READ_W-1:0] row,
                                    input logic [READ_W-1:0] rd,
                                    input logic sk_en,
                                    input logic [DET_W-1:0] sk_idx);
    near_t             n;
    logic [DIST_W-1:0] d;
    n.idx = '0;
    n.gap = DIST_W'(ENC_RANGE);
    for (int j = 0; j < DETENTS; j++) begin
      d = wrap_dist(rd, row[j]);
      if (!(sk_en && (DET_W'(j) == sk_idx)) && (d < n.gap)) begin
        n.gap = d;
        n.idx = DET_W'(j);
      end
    end
    return n;
  endfunction

  assign motor_ok  = {1'b0, item.motor} < (MOTOR_W+1)'(MOTORS);
  assign mi        = item.motor[MOT_W-1:0];
  assign skip_en   = item.selective && start_vld_r[mi];
  assign near_all  = nearest(detents, item.reading, 1'b0, '0);
  assign near_skip = nearest(detents, item.reading, skip_en, start_idx_r[mi]);
  assign tv        = detents[near_skip.idx];
  assign cnt_inc   = (cnt_r == '1) ? cnt_r : cnt_r + PASS_W'(1);
  assign limit     = item.selective ? cfg.align_to : cfg.home_to;
  assign step_s    = $signed(POS_W'(cfg.step));

  always_comb begin
    pos_nxt       = pos_r;
    start_idx_nxt = start_idx_r;
    start_vld_nxt = start_vld_r;
    moved_nxt     = moved_r;
    aligned_nxt   = aligned_r;
    cnt_nxt       = cnt_r;
    res.motor_out = item.motor;
    res.in_tol    = 1'b0;
    res.target    = '0;
    res.status    = ST_ACK;
    case (item.cmd)
      CMD_CLEAR: begin
        for (int m = 0; m < MOTORS; m++) begin
          start_idx_nxt[m] = '0;
        end
        start_vld_nxt = '0;
        moved_nxt     = '0;
      end
      CMD_RECORD: begin
        if (motor_ok) begin
          start_idx_nxt[mi] = near_all.idx;
          start_vld_nxt[mi] = 1'b1;
          if (item.mark) begin
            moved_nxt[mi] = 1'b1;
          end
          res.target = detents[near_all.idx];
        end
      end
      CMD_BEGIN: begin
        cnt_nxt     = '0;
        aligned_nxt = 1'b1;
      end
      CMD_ALIGN: begin
        if (motor_ok) begin
          if (item.selective && !moved_r[mi]) begin
            res.in_tol = 1'b1;
          end else begin
            res.target = tv;
            if (near_skip.gap > DIST_W'(cfg.tol)) begin
              aligned_nxt = 1'b0;
              if (item.reading > tv) begin
                pos_nxt[mi] = pos_r[mi] + step_s;
              end else begin
                pos_nxt[mi] = pos_r[mi] - step_s;
              end
            end else begin
              res.in_tol = 1'b1;
            end
          end
        end
      end
      CMD_END: begin
        res.in_tol  = aligned_r;
        cnt_nxt     = cnt_inc;
        aligned_nxt = 1'b1;
        if (cnt_inc > limit) begin
          res.status = ST_TIMEOUT;
          cnt_nxt    = '0;
        end else if (aligned_r) begin
          res.status = ST_SUCCESS;
          cnt_nxt    = '0;
          for (int m = 0; m < MOTORS; m++) begin
            pos_nxt[m] = '0;
          end
        end
      end
      default: ;
    endcase
    res.position = motor_ok ? pos_nxt[mi] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < MOTORS; m++) begin
        pos_r[m]       <= '0;
        start_idx_r[m] <= '0;
      end
      start_vld_r <= '0;
      moved_r     <= '0;
      aligned_r   <= 1'b1;
      cnt_r       <= '0;
    end else if (adv) begin
      pos_r       <= pos_nxt;
      start_idx_r <= start_idx_nxt;
      start_vld_r <= start_vld_nxt;
      moved_r     <= moved_nxt;
      aligned_r   <= aligned_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  `ASSERT_NXT(a_end_rearms, adv && (item.cmd == CMD_END), aligned_r)
  `ASSERT_NXT(a_begin_clears, adv && (item.cmd == CMD_BEGIN), cnt_r == '0)
  `ASSERT_NXT(a_success_zeroes, adv && (res.status == ST_SUCCESS), pos_r[0] == '0)

endmodule

FILE: sv/detent_alignment_stepper.sv
// A request waits in the request stage with its detent row, the only registered lookup;
// its result then goes to the result register. Throughput: one request per clock while
// out_ready holds; the result register is refilled while the previous result is taken.
// Reset: synchronous, active-low rst_n clears handshake state, positions, marks and pass
// counters, and loads register defaults; the detent table keeps no reset and needs none.
`include "assert_macros.svh"
module detent_alignment_stepper
  import das_pkg::*;
#(
  parameter int MOTORS  = MOTORS_DEF,
  parameter int DETENTS = DETENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_command,
  input  logic [MOTOR_W-1:0]       in_motor,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic [READ_W-1:0]        in_reading,
  input  logic                     in_selective,
  input  logic                     in_mark_moved,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MOTOR_W-1:0]       out_motor_out,
  output logic signed [POS_W-1:0]  out_position,
  output logic                     out_in_tolerance,
  output logic [READ_W-1:0]        out_target_detent,
  output logic [1:0]               out_run_status,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  localparam int MOT_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int DET_W = $clog2(DETENTS);

  cfg_t                           cfg;
  item_t                          in_item;
  item_t                          s1_item_r;
  logic                           s1_valid_r;
  res_t                           core_res;
  res_t                           out_res_r;
  logic                           out_valid_r;
  logic [DETENTS-1:0][READ_W-1:0] row;
  logic                           accept, adv;
  logic                           motor_ok, slot_ok;
  logic [SLOT_W+1:0]              slot_x;

  // Register file behind the APB-style port.
  das_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pack the incoming request.
  always_comb begin
    in_item.cmd       = cmd_e'(in_command);
    in_item.motor     = in_motor;
    in_item.reading   = in_reading;
    in_item.selective = in_selective;
    in_item.mark      = in_mark_moved;
  end

  // Advance the request stage when the result register is free or being drained;
  // accept a new request whenever the request stage is empty or empties in this cycle.
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign accept   = in_valid && in_ready;

  assign motor_ok = {1'b0, in_motor} < (MOTOR_W+1)'(MOTORS);
  assign slot_x   = (SLOT_W+2)'(in_slot);
  assign slot_ok  = slot_x < (SLOT_W+2)'(DETENTS);

  // Detent loads are written at acceptance, and every request reads its motor's row
  // at acceptance, so writes and reads stay in request order.
  das_detent_mem #(
    .MOTORS  (MOTORS),
    .DETENTS (DETENTS)
  ) u_mem (
    .clk      (clk),
    .wr_en    (accept && (in_item.cmd == CMD_LOAD) && motor_ok && slot_ok),
    .wr_motor (in_motor[MOT_W-1:0]),
    .wr_slot  (slot_x[DET_W-1:0]),
    .wr_data  (in_reading),
    .rd_en    (accept),
    .rd_motor (in_motor[MOT_W-1:0]),
    .rd_data  (row)
  );

  // Request stage: hold the request alongside the registered detent row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  // Nearest-detent search, stepping and pass bookkeeping; state commits on adv.
  das_align_core #(
    .MOTORS  (MOTORS),
    .DETENTS (DETENTS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .item    (s1_item_r),
    .detents (row),
    .cfg     (cfg),
    .res     (core_res)
  );

  // Result register: load on adv, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_motor_out     = out_res_r.motor_out;
  assign out_position      = out_res_r.position;
  assign out_in_tolerance  = out_res_r.in_tol;
  assign out_target_detent = out_res_r.target;
  assign out_run_status    = out_res_r.status;

  `ASSERT_IMP(a_empty_stage_ready, !s1_valid_r, in_ready)
  `ASSERT_NXT(a_accept_fills, accept, s1_valid_r)
  `ASSERT_NXT(a_adv_loads_out, adv, out_valid_r)
  `ASSERT_NXT(a_stall_holds, s1_valid_r && !adv, s1_valid_r && $stable(s1_item_r))

endmodule
